[sv/ped_pkg.sv]
// ----------------------------------------------------------------------------
// ped_pkg
// Shared sizes, opcodes and control types of the Potts energy difference core.
// ----------------------------------------------------------------------------
package ped_pkg;

  localparam int MAX_SITES  = 64;
  localparam int MAX_STATES = 32;

  localparam int SITE_W  = $clog2(MAX_SITES);
  localparam int STATE_W = $clog2(MAX_STATES);
  localparam int NS_W    = 7;
  localparam int VAL_W   = 32;
  localparam int DIFF_W  = 33;
  localparam int ACC_W   = 48;

  localparam int FLD_ADDR_W = SITE_W + STATE_W;
  localparam int FLD_DEPTH  = MAX_SITES * MAX_STATES;
  localparam int CPL_ADDR_W = 2 * SITE_W + 2 * STATE_W;
  localparam int CPL_DEPTH  = MAX_SITES * MAX_SITES * MAX_STATES * MAX_STATES;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic [1:0] OP_COUPLING = 2'd0;
  localparam logic [1:0] OP_FIELD    = 2'd1;
  localparam logic [1:0] OP_SYMBOL   = 2'd2;

  typedef struct packed {
    logic add;
    logic clear;
  } acc_ctrl_t;

endpackage

[sv/ped_ram.sv]
// ----------------------------------------------------------------------------
// ped_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ped_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/ped_sat_acc.sv]
// ----------------------------------------------------------------------------
// ped_sat_acc
// Shared saturating 48-bit accumulator with a sticky clip flag.
// ----------------------------------------------------------------------------
module ped_sat_acc (
  input  logic                              clk,
  input  logic                              rst,
  input  ped_pkg::acc_ctrl_t                ctrl,
  input  logic signed [ped_pkg::DIFF_W-1:0] term,
  output logic signed [ped_pkg::ACC_W-1:0]  acc,
  output logic                              clip
);

  import ped_pkg::*;

  logic signed [ACC_W:0]   sum;
  logic                    ovf;
  logic signed [ACC_W-1:0] acc_next;

  always_comb begin
    sum = {acc[ACC_W-1], acc} + (ACC_W+1)'(term);
    ovf = sum[ACC_W] != sum[ACC_W-1];
    if (ovf) begin
      acc_next = sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_next = sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      acc  <= '0;
      clip <= 1'b0;
    end else if (ctrl.add) begin
      acc  <= acc_next;
      clip <= clip | ovf;
    end
  end

endmodule

[sv/potts_energy_difference_core.sv]
// Load items (field or coupling writes) go straight into the tables; they are stalled while the core is not idle.
// A symbol at sequence position p adds its field term, then p coupling terms: one coupling
// RAM read per earlier site, streamed through the symbol RAM, coupling RAM and the accumulator.
// After the last symbol of a sequence the result register is loaded in the EMIT state.
// rst is synchronous: position, accumulator and clip flag clear, num_sites returns to 64;
// table contents are not cleared.
// ----------------------------------------------------------------------------
// potts_energy_difference_core
// Trial-minus-reference Potts energy of symbol sequences from stored differences.
// ----------------------------------------------------------------------------
module potts_energy_difference_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ped_pkg::NS_W-1:0]           num_sites,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic [1:0]                         opcode,
  input  logic [5:0]                         first_site,
  input  logic [5:0]                         second_site,
  input  logic [4:0]                         first_state,
  input  logic [4:0]                         second_state,
  input  logic signed [ped_pkg::VAL_W-1:0]   trial_value,
  input  logic signed [ped_pkg::VAL_W-1:0]   reference_value,
  input  logic [4:0]                         symbol,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic signed [ped_pkg::ACC_W-1:0]   energy_difference,
  output logic                               saturated
);

  import ped_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_EMIT
  } state_t;

  state_t              state;
  logic [SITE_W-1:0]   pos;
  logic [SITE_W-1:0]   k;
  logic [SITE_W-1:0]   k_d1;
  logic [STATE_W-1:0]  sym;
  logic                fld_v;
  logic                v1;
  logic                v2;
  logic [NS_W-1:0]     site_count;

  logic                item_fire;
  logic                issue;
  logic                done;
  logic                last;
  logic                emit_fire;
  logic [NS_W-1:0]     n_eff;
  logic signed [DIFF_W-1:0] diff;

  logic                fld_we;
  logic                cpl_we;
  logic [DIFF_W-1:0]   fld_rdata;
  logic [DIFF_W-1:0]   cpl_rdata;
  logic [STATE_W-1:0]  seq_rdata;

  acc_ctrl_t                acc_ctrl;
  logic signed [DIFF_W-1:0] term;
  logic signed [ACC_W-1:0]  acc;
  logic                     clip;

  assign item_stall = (state != S_IDLE);
  assign cfg_ready  = (state == S_IDLE);
  assign item_fire  = item_valid && !item_stall;
  assign issue      = (state == S_RUN) && (k != pos);
  assign done       = (state == S_RUN) && (k == pos) && !fld_v && !v1 && !v2;
  assign emit_fire  = (state == S_EMIT) && (!result_valid || !result_stall);

  always_comb begin
    if (site_count == '0) begin
      n_eff = NS_W'(1);
    end else if (int'(site_count) > MAX_SITES) begin
      n_eff = NS_W'(MAX_SITES);
    end else begin
      n_eff = site_count;
    end
    last = (NS_W'(pos) + NS_W'(1)) >= n_eff;
  end

  assign diff = DIFF_W'(trial_value) - DIFF_W'(reference_value);

  assign fld_we = item_fire && (opcode == OP_FIELD) && (int'(first_site) < MAX_SITES)
                  && (int'(first_state) < MAX_STATES);
  assign cpl_we = item_fire && (opcode == OP_COUPLING) && (first_site < second_site)
                  && (int'(second_site) < MAX_SITES) && (int'(first_state) < MAX_STATES)
                  && (int'(second_state) < MAX_STATES);

  ped_ram #(
    .WIDTH (DIFF_W),
    .DEPTH (FLD_DEPTH)
  ) u_field_ram (
    .clk   (clk),
    .we    (fld_we),
    .waddr ({first_site[SITE_W-1:0], first_state[STATE_W-1:0]}),
    .wdata (diff),
    .re    (item_fire && (opcode == OP_SYMBOL)),
    .raddr ({pos, symbol[STATE_W-1:0]}),
    .rdata (fld_rdata)
  );

  ped_ram #(
    .WIDTH (STATE_W),
    .DEPTH (MAX_SITES)
  ) u_symbol_ram (
    .clk   (clk),
    .we    (done),
    .waddr (pos),
    .wdata (sym),
    .re    (issue),
    .raddr (k),
    .rdata (seq_rdata)
  );

  ped_ram #(
    .WIDTH (DIFF_W),
    .DEPTH (CPL_DEPTH)
  ) u_coupling_ram (
    .clk   (clk),
    .we    (cpl_we),
    .waddr ({first_site[SITE_W-1:0], second_site[SITE_W-1:0],
             first_state[STATE_W-1:0], second_state[STATE_W-1:0]}),
    .wdata (diff),
    .re    (v1),
    .raddr ({k_d1, pos, seq_rdata, sym}),
    .rdata (cpl_rdata)
  );

  assign acc_ctrl.add   = fld_v || v2;
  assign acc_ctrl.clear = emit_fire;
  assign term           = fld_v ? signed'(fld_rdata) : signed'(cpl_rdata);

  ped_sat_acc u_acc (
    .clk  (clk),
    .rst  (rst),
    .ctrl (acc_ctrl),
    .term (term),
    .acc  (acc),
    .clip (clip)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pos          <= '0;
      k            <= '0;
      fld_v        <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      result_valid <= 1'b0;
      site_count   <= NS_W'(MAX_SITES);
    end else begin
      fld_v <= item_fire && (opcode == OP_SYMBOL);
      v1    <= issue;
      v2    <= v1;
      k_d1  <= k;
      if (cfg_valid && cfg_ready) begin
        site_count <= num_sites;
      end
      if (issue) begin
        k <= k + SITE_W'(1);
      end
      if (result_valid && !result_stall && !emit_fire) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_fire && (opcode == OP_SYMBOL)) begin
            sym   <= symbol[STATE_W-1:0];
            k     <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (done) begin
            if (last) begin
              state <= S_EMIT;
            end else begin
              pos   <= pos + SITE_W'(1);
              state <= S_IDLE;
            end
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            energy_difference <= acc;
            saturated         <= clip;
            result_valid      <= 1'b1;
            pos               <= '0;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_term: assert property (@(posedge clk) disable iff (rst) !(fld_v && v2))
    else $error("field and coupling terms collide at the accumulator");
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!v1 && !v2 && !fld_v))
    else $error("read pipeline busy while idle");
  a_symbol_starts: assert property (@(posedge clk) disable iff (rst)
    (item_fire && (opcode == OP_SYMBOL)) |=> (state == S_RUN && fld_v))
    else $error("symbol transaction did not start the sequencer");
  a_clip_at_limit: assert property (@(posedge clk) disable iff (rst)
    $rose(clip) |-> (acc == ACC_MAX || acc == ACC_MIN))
    else $error("clip flag raised without a saturated accumulator");
`endif

endmodule
